@@ hw/rtl/ipcf_pkg.sv @@
// Shared types, constants and tables of the pitch complementary filter.
`timescale 1ns / 1ps
package ipcf_pkg;

	// Fixed-point configuration
	localparam int CORDIC_ITERATIONS = 16;
	localparam int PITCH_FRAC_BITS   = 16;
	localparam int ATAN_LEN          = 24;
	localparam int ATAN_IDX_W        = $clog2(ATAN_LEN);

	// Rate scaling: |gy| (17 bits) times 2^PITCH_FRAC_BITS / 131
	localparam int DIV_BITS     = 17 + PITCH_FRAC_BITS;
	localparam int CNT_W        = ATAN_IDX_W;
	localparam int RATE_DIVISOR = 131;
	// Reciprocal ceil(2^(RECIP_SHIFT+F) / 131); exact floor for |gy| below 2^16
	localparam int RECIP_SHIFT  = 24;
	localparam logic [DIV_BITS-1:0] RATE_RECIP = DIV_BITS'(
		((64'd1 << (RECIP_SHIFT + PITCH_FRAC_BITS)) + 64'(RATE_DIVISOR - 1))
		/ 64'(RATE_DIVISOR));

	// Datapath widths
	localparam int DIFF_W = 17;
	localparam int CX_W   = 28;
	localparam int CZ_W   = 32;
	localparam int PE_W   = PITCH_FRAC_BITS + 10;
	localparam int PRED_W = PE_W + 2;
	localparam int ACC_W  = PITCH_FRAC_BITS + 9;
	localparam int RATE_W = DIV_BITS + 1;
	localparam int SUM_W  = PRED_W + 19;

	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_AX_OFS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AY_OFS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AZ_OFS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GY_OFS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd5;

	localparam logic [15:0] ALPHA_RESET  = 16'd64225;
	localparam logic [15:0] PERIOD_RESET = 16'd4194;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VEC1,
		ST_GAIN,
		ST_VEC2_INIT,
		ST_VEC2,
		ST_ANGLE,
		ST_DIV,
		ST_PRED,
		ST_MUL,
		ST_SAT,
		ST_OUT
	} ctl_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic             load;
		logic             rot;
		logic             gain;
		logic             vec2_init;
		logic             angle;
		logic             div;
		logic             pred;
		logic             mul;
		logic             sat;
		logic             out_load;
		logic [CNT_W-1:0] idx;
	} ipcf_cmd_t;

	// Arctangent of 2^-i in degrees, Q24
	function automatic logic signed [CZ_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] i);
		logic signed [CZ_W-1:0] v;
		unique case (i)
			5'd0:    v = 32'sd754974720;
			5'd1:    v = 32'sd445687602;
			5'd2:    v = 32'sd235489088;
			5'd3:    v = 32'sd119537938;
			5'd4:    v = 32'sd60000934;
			5'd5:    v = 32'sd30029717;
			5'd6:    v = 32'sd15018523;
			5'd7:    v = 32'sd7509720;
			5'd8:    v = 32'sd3754917;
			5'd9:    v = 32'sd1877466;
			5'd10:   v = 32'sd938734;
			5'd11:   v = 32'sd469367;
			5'd12:   v = 32'sd234684;
			5'd13:   v = 32'sd117342;
			5'd14:   v = 32'sd58671;
			5'd15:   v = 32'sd29335;
			5'd16:   v = 32'sd14668;
			5'd17:   v = 32'sd7334;
			5'd18:   v = 32'sd3667;
			5'd19:   v = 32'sd1833;
			5'd20:   v = 32'sd917;
			5'd21:   v = 32'sd458;
			5'd22:   v = 32'sd229;
			5'd23:   v = 32'sd115;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ hw/rtl/ipcf_ctrl.sv @@
// Sequencer of the pitch filter: steps the datapath through each sample.
`timescale 1ns / 1ps
module ipcf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ipcf_pkg::ipcf_cmd_t cmd
);
	import ipcf_pkg::*;

	ctl_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             iter_last, out_free;

	assign iter_last = (cnt_q == CNT_W'(CORDIC_ITERATIONS - 1));
	assign out_free  = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_VEC1;
			ST_VEC1:      if (iter_last) state_d = ST_GAIN;
			ST_GAIN:      state_d = ST_VEC2_INIT;
			ST_VEC2_INIT: state_d = ST_VEC2;
			ST_VEC2:      if (iter_last) state_d = ST_ANGLE;
			ST_ANGLE:     state_d = ST_DIV;
			ST_DIV:       state_d = ST_PRED;
			ST_PRED:      state_d = ST_MUL;
			ST_MUL:       state_d = ST_SAT;
			ST_SAT:       state_d = ST_OUT;
			ST_OUT:       if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd       = '0;
		cmd.idx   = cnt_q;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_VEC1, ST_VEC2: cmd.rot = 1'b1;
			ST_GAIN:          cmd.gain = 1'b1;
			ST_VEC2_INIT:     cmd.vec2_init = 1'b1;
			ST_ANGLE:         cmd.angle = 1'b1;
			ST_DIV:           cmd.div = 1'b1;
			ST_PRED:          cmd.pred = 1'b1;
			ST_MUL:           cmd.mul = 1'b1;
			ST_SAT:           cmd.sat = 1'b1;
			ST_OUT:           cmd.out_load = out_free;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	// State, step counter and output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ hw/rtl/ipcf_dp.sv @@
// Datapath of the pitch filter: CORDIC, rate scaling, blend and registers.
`timescale 1ns / 1ps
module ipcf_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ipcf_pkg::ipcf_cmd_t       cmd,
	input  logic                      cfg_we,
	input  logic [ipcf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic signed [15:0]        accel_x_raw,
	input  logic signed [15:0]        accel_y_raw,
	input  logic signed [15:0]        accel_z_raw,
	input  logic signed [15:0]        gyro_y_raw,
	output logic signed [16:0]        pitch_angle,
	output logic signed [17:0]        gyro_rate
);
	import ipcf_pkg::*;

	// Configuration registers
	logic signed [15:0] ax_ofs_q, ay_ofs_q, az_ofs_q, gy_ofs_q;
	logic [15:0]        alpha_q, period_q;

	// Working registers
	logic signed [DIFF_W-1:0] ax_q;
	logic                     gy_neg_q;
	logic [DIFF_W-1:0]        gy_mag_q;
	logic signed [CX_W-1:0]   x_q, y_q;
	logic signed [CZ_W-1:0]   z_q;
	logic signed [CX_W+30:0]  gain_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [DIV_BITS-1:0]      quo_q;
	logic signed [PRED_W-1:0] pred_q;
	logic signed [PRED_W+17:0] p1_q;
	logic signed [ACC_W+17:0]  p2_q;
	logic signed [PE_W-1:0]   pe_q;
	logic signed [16:0]       angle_q;
	logic signed [17:0]       rate_q;

	logic signed [DIFF_W-1:0] ax_d, ay_d, az_d, gy_d;
	logic [DIFF_W-1:0]        ay_abs, az_abs, gy_abs;
	logic [ATAN_IDX_W-1:0]    i;
	logic signed [CX_W-1:0]   dx, dy;
	logic signed [CZ_W-1:0]   z_sh;
	logic signed [ACC_W-1:0]  z_cl;
	logic [DIFF_W+DIV_BITS-1:0] quo_prod;
	logic signed [RATE_W-1:0] rate_s;
	logic signed [RATE_W+16:0] rdt;
	logic signed [SUM_W-1:0]  sum, sum_sh;
	logic signed [PE_W-1:0]   sat_v;
	logic [DIV_BITS-1:0]      rate_mag;

	localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(90) <<< PITCH_FRAC_BITS;
	localparam logic signed [SUM_W-1:0] PE_LIM  = SUM_W'(180) <<< PITCH_FRAC_BITS;

	// Offset removal
	assign ax_d = $signed({accel_x_raw[15], accel_x_raw}) - $signed({ax_ofs_q[15], ax_ofs_q});
	assign ay_d = $signed({accel_y_raw[15], accel_y_raw}) - $signed({ay_ofs_q[15], ay_ofs_q});
	assign az_d = $signed({accel_z_raw[15], accel_z_raw}) - $signed({az_ofs_q[15], az_ofs_q});
	assign gy_d = $signed({gyro_y_raw[15], gyro_y_raw}) - $signed({gy_ofs_q[15], gy_ofs_q});
	assign ay_abs = ay_d[DIFF_W-1] ? DIFF_W'(-ay_d) : DIFF_W'(ay_d);
	assign az_abs = az_d[DIFF_W-1] ? DIFF_W'(-az_d) : DIFF_W'(az_d);
	assign gy_abs = gy_d[DIFF_W-1] ? DIFF_W'(-gy_d) : DIFF_W'(gy_d);

	// CORDIC vectoring step
	assign i  = cmd.idx[ATAN_IDX_W-1:0];
	assign dx = y_q >>> i;
	assign dy = x_q >>> i;

	// Angle scale and clamp to +/-90 degrees
	assign z_sh = z_q >>> (24 - PITCH_FRAC_BITS);
	always_comb begin
		if (z_sh > CZ_W'(ACC_LIM)) z_cl = ACC_LIM;
		else if (z_sh < -CZ_W'(ACC_LIM)) z_cl = -ACC_LIM;
		else z_cl = ACC_W'(z_sh);
	end

	// Floor of |gy| * 2^F / 131 by reciprocal multiplication
	assign quo_prod = gy_mag_q * RATE_RECIP;

	// Gyro prediction
	assign rate_s = gy_neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign rdt    = rate_s * $signed({1'b0, period_q});

	// Blend sum and saturation to +/-180 degrees
	assign sum    = SUM_W'(p1_q) + SUM_W'(p2_q);
	assign sum_sh = sum >>> 16;
	always_comb begin
		if (sum_sh > PE_LIM) sat_v = PE_W'(PE_LIM);
		else if (sum_sh < -PE_LIM) sat_v = PE_W'(-PE_LIM);
		else sat_v = PE_W'(sum_sh);
	end

	assign rate_mag = quo_q >> (PITCH_FRAC_BITS - 8);

	// Configuration writes and kept pitch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_ofs_q <= '0;
			ay_ofs_q <= '0;
			az_ofs_q <= '0;
			gy_ofs_q <= '0;
			alpha_q  <= ALPHA_RESET;
			period_q <= PERIOD_RESET;
			pe_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_AX_OFS: ax_ofs_q <= cfg_data;
					REG_AY_OFS: ay_ofs_q <= cfg_data;
					REG_AZ_OFS: az_ofs_q <= cfg_data;
					REG_GY_OFS: gy_ofs_q <= cfg_data;
					REG_ALPHA:  alpha_q  <= cfg_data;
					REG_PERIOD: period_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.sat) pe_q <= sat_v;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q     <= ax_d;
			gy_neg_q <= gy_d[DIFF_W-1];
			gy_mag_q <= gy_abs;
			x_q      <= $signed(CX_W'(ay_abs) << 8);
			y_q      <= $signed(CX_W'(az_abs) << 8);
			z_q      <= '0;
		end
		if (cmd.rot) begin
			if (!y_q[CX_W-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_q24(i);
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_q24(i);
			end
		end
		if (cmd.gain) gain_q <= x_q * $signed({1'b0, INV_GAIN_Q30});
		if (cmd.vec2_init) begin
			x_q <= CX_W'(gain_q >>> 30);
			y_q <= CX_W'(ax_q) <<< 8;
			z_q <= '0;
		end
		if (cmd.angle) acc_q <= (ax_q == '0) ? '0 : z_cl;
		if (cmd.div) quo_q <= DIV_BITS'(quo_prod >> RECIP_SHIFT);
		if (cmd.pred) pred_q <= PRED_W'(pe_q) + PRED_W'(rdt >>> 20);
		if (cmd.mul) begin
			p1_q <= pred_q * $signed({2'b00, alpha_q});
			p2_q <= acc_q * $signed(18'(32'd65536 - 32'(alpha_q)));
		end
		if (cmd.out_load) begin
			angle_q <= 17'(pe_q >>> (PITCH_FRAC_BITS - 8));
			rate_q  <= gy_neg_q ? -$signed(18'(rate_mag)) : $signed(18'(rate_mag));
		end
	end

	assign pitch_angle = angle_q;
	assign gyro_rate   = rate_q;

endmodule

@@ hw/rtl/imu_pitch_complementary_filter.sv @@
// Pitch complementary filter: top level with stream ports and config channel.
`timescale 1ns / 1ps
// One sample beat (accelerometer triple and gyro Y) yields one result beat with
// the filtered pitch in 1/256 degree and the gyro rate in 1/256 degree per
// second units. A sample runs through two CORDIC vectoring passes of one
// rotation per cycle, with gain and pass setup between the passes, then angle
// clamp, rate scaling by a reciprocal multiply, prediction, blend, saturation
// and output load in that order, before the next sample is accepted. The
// result sits in an output register, so a new sample is taken while the
// previous result waits; that sample stalls before its output load until the
// waiting beat is taken. Write configuration only while the block is idle.
module imu_pitch_complementary_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// accel_x_raw[15:0], accel_y_raw[31:16], accel_z_raw[47:32], gyro_y_raw[63:48]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pitch_angle[16:0], gyro_rate[34:17], zero fill [39:35]
	output logic [39:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ipcf_pkg::*;

	ipcf_cmd_t          cmd;
	logic signed [16:0] pitch_angle;
	logic signed [17:0] gyro_rate;

	assign cfg_ready = 1'b1;

	ipcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	ipcf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accel_x_raw (s_tdata[15:0]),
		.accel_y_raw (s_tdata[31:16]),
		.accel_z_raw (s_tdata[47:32]),
		.gyro_y_raw  (s_tdata[63:48]),
		.pitch_angle (pitch_angle),
		.gyro_rate   (gyro_rate)
	);

	assign m_tdata = {5'b0, gyro_rate, pitch_angle};

`ifndef SYNTHESIS
	// An accepted sample blocks the input until its work is done
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after accepting a sample");

	// A shown pitch stays within +/-180 degrees
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[16:0]) <= 17'sd46080 &&
			$signed(m_tdata[16:0]) >= -17'sd46080))
		else $error("pitch out of range");

	// A new result beat only follows an output load
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("result beat without output load");
`endif

endmodule
